// ----- rtl/core/sst_pkg.sv -----
// Package for the sparse triplet table: sizes, codes, the stored triplet
// layout and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

  localparam int CAPACITY   = 64;
  localparam int MAX_DIM    = 255;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int DIM_W      = 8;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 3;
  localparam int ENTRY_W    = 7;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int KEY_W      = 2 * DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT    = 2'd0,
    REQ_LOOKUP    = 2'd1,
    REQ_TRANSPOSE = 2'd2,
    REQ_CLEAR     = 2'd3
  } sst_req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } sst_status_t;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_CLR  = 3'd1,
    IDX_INC  = 3'd2,
    IDX_DEC  = 3'd3,
    IDX_TOP  = 3'd4
  } sst_idx_op_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_VAL   = 2'd1,
    WR_SHIFT = 2'd2,
    WR_NEW   = 2'd3
  } sst_wr_op_t;

  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic [VAL_W-1:0] value;
  } sst_entry_t;

  typedef struct packed {
    logic        in_take;
    sst_idx_op_t idx_op;
    logic        mark_p;
    sst_wr_op_t  wr_op;
    logic        cnt_inc;
    logic        cnt_clr;
    logic        res_set;
    sst_status_t res_code;
    logic        res_from_rd;
    logic        tr_begin;
    logic        tr_scan;
    logic        tr_emit;
    logic        out_load;
  } sst_cmd_t;

  typedef struct packed {
    logic     in_valid;
    sst_req_t req;
    logic     full;
    logic     bad_pos;
    logic     idx_lt_n;
    logic     key_lt;
    logic     key_eq;
    logic     idx_eq_p;
    logic     cnt_zero;
    logic     res_last;
    logic     out_free;
  } sst_sts_t;

endpackage

// ----- rtl/core/sst_if.sv -----
// Channel interfaces of the sparse triplet table: request words in, result
// words out, each with a valid/ready handshake. Depends on sst_pkg.
`timescale 1ns / 1ps

interface sst_in_if;
  logic                      valid;
  logic                      ready;
  logic [sst_pkg::REQ_W-1:0] req_type;
  logic [sst_pkg::DIM_W-1:0] row;
  logic [sst_pkg::DIM_W-1:0] col;
  logic [sst_pkg::VAL_W-1:0] value;

  modport source (output valid, req_type, row, col, value, input ready);
  modport sink (input valid, req_type, row, col, value, output ready);
endinterface

interface sst_out_if;
  logic                        valid;
  logic                        ready;
  logic [sst_pkg::STAT_W-1:0]  status;
  logic [sst_pkg::DIM_W-1:0]   out_row;
  logic [sst_pkg::DIM_W-1:0]   out_col;
  logic [sst_pkg::VAL_W-1:0]   out_value;
  logic [sst_pkg::ENTRY_W-1:0] entry_total;
  logic                        last;

  modport source (output valid, status, out_row, out_col, out_value, entry_total, last,
                  input ready);
  modport sink (input valid, status, out_row, out_col, out_value, entry_total, last,
                output ready);
endinterface

// ----- rtl/core/sst_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/sst_ctrl.sv -----
// Controller of the sparse triplet table: sequences insert, lookup,
// transpose and clear. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  sst_pkg::sst_sts_t sts,
  output sst_pkg::sst_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_FIND     = 8'b0000_0100,
    S_SHIFT    = 8'b0000_1000,
    S_PUT      = 8'b0001_0000,
    S_LOOKUP   = 8'b0010_0000,
    S_TR_SCAN  = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.idx_op      = sst_pkg::IDX_HOLD;
    cmd.wr_op       = sst_pkg::WR_NONE;
    cmd.res_code    = sst_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        cmd.in_take = 1'b1;
        cmd.idx_op  = sst_pkg::IDX_CLR;
        if (sts.in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.req)
          sst_pkg::REQ_INSERT: begin
            if (sts.full) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = sst_pkg::ST_FULL;
              state_nxt    = S_RESP;
            end else if (sts.bad_pos) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = sst_pkg::ST_RANGE;
              state_nxt    = S_RESP;
            end else begin
              state_nxt = S_FIND;
            end
          end
          sst_pkg::REQ_LOOKUP: begin
            state_nxt = S_LOOKUP;
          end
          sst_pkg::REQ_TRANSPOSE: begin
            if (sts.cnt_zero) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = sst_pkg::ST_EMPTY;
              state_nxt    = S_RESP;
            end else begin
              cmd.tr_begin = 1'b1;
              state_nxt    = S_TR_SCAN;
            end
          end
          default: begin
            cmd.cnt_clr = 1'b1;
            cmd.res_set = 1'b1;
            state_nxt   = S_RESP;
          end
        endcase
      end
      S_FIND: begin
        if (sts.idx_lt_n && sts.key_lt) begin
          cmd.idx_op = sst_pkg::IDX_INC;
        end else if (sts.idx_lt_n && sts.key_eq) begin
          cmd.wr_op   = sst_pkg::WR_VAL;
          cmd.res_set = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          cmd.mark_p = 1'b1;
          if (sts.idx_lt_n) begin
            cmd.idx_op = sst_pkg::IDX_TOP;
            state_nxt  = S_SHIFT;
          end else begin
            state_nxt = S_PUT;
          end
        end
      end
      S_SHIFT: begin
        cmd.wr_op = sst_pkg::WR_SHIFT;
        if (sts.idx_eq_p) begin
          state_nxt = S_PUT;
        end else begin
          cmd.idx_op = sst_pkg::IDX_DEC;
        end
      end
      S_PUT: begin
        cmd.wr_op   = sst_pkg::WR_NEW;
        cmd.cnt_inc = 1'b1;
        cmd.res_set = 1'b1;
        state_nxt   = S_RESP;
      end
      S_LOOKUP: begin
        if (!sts.idx_lt_n) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = sst_pkg::ST_NOTFOUND;
          state_nxt    = S_RESP;
        end else if (sts.key_eq) begin
          cmd.res_set     = 1'b1;
          cmd.res_from_rd = 1'b1;
          state_nxt       = S_RESP;
        end else begin
          cmd.idx_op = sst_pkg::IDX_INC;
        end
      end
      S_TR_SCAN: begin
        cmd.tr_scan = 1'b1;
        if (sts.idx_lt_n) begin
          cmd.idx_op = sst_pkg::IDX_INC;
        end else begin
          cmd.tr_emit = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_RESP: begin
        cmd.idx_op = sst_pkg::IDX_CLR;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.res_last ? S_IDLE : S_TR_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_shift_follows_find: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> ($past(state_r) == S_FIND || $past(state_r) == S_SHIFT))
    else $error("shift entered from an unexpected state");

  a_idle_takes_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISPATCH) |-> $past(state_r) == S_IDLE)
    else $error("dispatch without an accepted word");

  a_put_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |=> (state_r == S_RESP))
    else $error("put not followed by response");
`endif

endmodule

// ----- rtl/core/sst_dp.sv -----
// Datapath of the sparse triplet table: triplet memory, index and count
// registers, key compares, transpose ordering and the result register.
// Depends on sst_pkg, sst_if and sst_ram.
`timescale 1ns / 1ps

module sst_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  sst_in_if.sink                        in_ch,
  sst_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sst_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  sst_pkg::sst_cmd_t             cmd,
  output sst_pkg::sst_sts_t             sts
);

  localparam logic [sst_pkg::CNT_W-1:0] CNT_ONE = sst_pkg::CNT_W'(1);
  localparam logic [sst_pkg::CNT_W-1:0] CNT_CAP = sst_pkg::CNT_W'(sst_pkg::CAPACITY);
  localparam logic [sst_pkg::DIM_W-1:0] DIM_MAX = sst_pkg::DIM_W'(sst_pkg::MAX_DIM);

  logic [sst_pkg::DIM_W-1:0] rows_r, cols_r;
  logic [sst_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [sst_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [sst_pkg::CNT_W-1:0] idx_inc;
  logic [sst_pkg::CNT_W-1:0] p_r;
  logic [sst_pkg::CNT_W-1:0] k_r;
  sst_pkg::sst_req_t         req_r;
  logic [sst_pkg::DIM_W-1:0] row_r, col_r;
  logic [sst_pkg::VAL_W-1:0] val_r;

  logic                      have_prev_r, best_v_r;
  logic [sst_pkg::KEY_W-1:0] prev_r, best_key_r;
  logic [sst_pkg::VAL_W-1:0] best_val_r;

  sst_pkg::sst_status_t      res_status_r;
  logic [sst_pkg::DIM_W-1:0] res_row_r, res_col_r;
  logic [sst_pkg::VAL_W-1:0] res_val_r;
  logic                      res_last_r;

  logic                        out_valid_r;
  sst_pkg::sst_status_t        out_status_r;
  logic [sst_pkg::DIM_W-1:0]   out_row_r, out_col_r;
  logic [sst_pkg::VAL_W-1:0]   out_val_r;
  logic [sst_pkg::ENTRY_W-1:0] out_total_r;
  logic                        out_last_r;

  sst_pkg::sst_entry_t       rdata, wdata;
  logic                      we;
  logic [sst_pkg::IDX_W-1:0] waddr;
  logic [sst_pkg::KEY_W-1:0] ekey, nkey, tkey;
  logic [sst_pkg::DIM_W-1:0] row_bound, col_bound;
  logic                      elig, best_upd, in_fire, out_free;

  assign in_ch.ready = cmd.in_take;
  assign in_fire     = in_ch.valid && cmd.in_take;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign idx_inc     = idx_r + CNT_ONE;

  always_comb begin
    case (cmd.idx_op)
      sst_pkg::IDX_CLR: idx_nxt = '0;
      sst_pkg::IDX_INC: idx_nxt = idx_inc;
      sst_pkg::IDX_DEC: idx_nxt = idx_r - CNT_ONE;
      sst_pkg::IDX_TOP: idx_nxt = cnt_r - CNT_ONE;
      default:          idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = idx_r[sst_pkg::IDX_W-1:0];
    wdata = rdata;
    case (cmd.wr_op)
      sst_pkg::WR_VAL: begin
        wdata.value = val_r;
      end
      sst_pkg::WR_SHIFT: begin
        waddr = idx_inc[sst_pkg::IDX_W-1:0];
      end
      sst_pkg::WR_NEW: begin
        waddr = p_r[sst_pkg::IDX_W-1:0];
        wdata = '{row: row_r, col: col_r, value: val_r};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  sst_ram #(
    .WIDTH($bits(sst_pkg::sst_entry_t)),
    .DEPTH(sst_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_nxt[sst_pkg::IDX_W-1:0]),
    .rdata (rdata)
  );

  assign row_bound = (rows_r > DIM_MAX) ? DIM_MAX : rows_r;
  assign col_bound = (cols_r > DIM_MAX) ? DIM_MAX : cols_r;
  assign ekey      = {rdata.row, rdata.col};
  assign nkey      = {row_r, col_r};
  assign tkey      = {rdata.col, rdata.row};
  assign elig      = !have_prev_r || (tkey > prev_r);
  assign best_upd  = cmd.tr_scan && (idx_r < cnt_r) && elig
                     && (!best_v_r || (tkey < best_key_r));

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_ONE;
    end
  end

  always_comb begin
    sts          = '0;
    sts.in_valid = in_ch.valid;
    sts.req      = req_r;
    sts.full     = cnt_r >= CNT_CAP;
    sts.bad_pos  = (row_r == '0) || (col_r == '0) || (row_r > row_bound)
                   || (col_r > col_bound);
    sts.idx_lt_n = idx_r < cnt_r;
    sts.key_lt   = ekey < nkey;
    sts.key_eq   = ekey == nkey;
    sts.idx_eq_p = idx_r == p_r;
    sts.cnt_zero = cnt_r == '0;
    sts.res_last = res_last_r;
    sts.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= sst_pkg::DIM_W'(16);
      cols_r      <= sst_pkg::DIM_W'(16);
      cnt_r       <= '0;
      idx_r       <= '0;
      k_r         <= '0;
      have_prev_r <= 1'b0;
      best_v_r    <= 1'b0;
      res_last_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sst_pkg::CFG_ROWS: rows_r <= cfg_wdata;
          sst_pkg::CFG_COLS: cols_r <= cfg_wdata;
          default: ;
        endcase
      end
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      if (cmd.tr_begin) begin
        k_r         <= '0;
        have_prev_r <= 1'b0;
        best_v_r    <= 1'b0;
      end else if (cmd.tr_emit) begin
        k_r         <= k_r + CNT_ONE;
        have_prev_r <= 1'b1;
        best_v_r    <= 1'b0;
      end else if (best_upd) begin
        best_v_r <= 1'b1;
      end
      if (cmd.res_set) begin
        res_last_r <= 1'b1;
      end else if (cmd.tr_emit) begin
        res_last_r <= (k_r + CNT_ONE) == cnt_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= sst_pkg::sst_req_t'(in_ch.req_type);
      row_r <= in_ch.row;
      col_r <= in_ch.col;
      val_r <= in_ch.value;
    end
    if (cmd.mark_p) begin
      p_r <= idx_r;
    end
    if (best_upd) begin
      best_key_r <= tkey;
      best_val_r <= rdata.value;
    end
    if (cmd.tr_emit) begin
      prev_r <= best_key_r;
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      res_row_r    <= '0;
      res_col_r    <= '0;
      res_val_r    <= cmd.res_from_rd ? rdata.value : '0;
    end else if (cmd.tr_emit) begin
      res_status_r <= sst_pkg::ST_OK;
      res_row_r    <= best_key_r[sst_pkg::KEY_W-1:sst_pkg::DIM_W];
      res_col_r    <= best_key_r[sst_pkg::DIM_W-1:0];
      res_val_r    <= best_val_r;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_row_r    <= res_row_r;
      out_col_r    <= res_col_r;
      out_val_r    <= res_val_r;
      out_total_r  <= sst_pkg::ENTRY_W'(cnt_r);
      out_last_r   <= res_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.out_row     = out_row_r;
  assign out_ch.out_col     = out_col_r;
  assign out_ch.out_value   = out_val_r;
  assign out_ch.entry_total = out_total_r;
  assign out_ch.last        = out_last_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_CAP)
    else $error("entry count beyond capacity");

  a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> cnt_r < CNT_CAP)
    else $error("new entry written into a full table");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_op == sst_pkg::WR_SHIFT) |-> (idx_r < cnt_r) && (idx_r >= p_r))
    else $error("shift outside the occupied range");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result word overwritten before it was taken");
`endif

endmodule

// ----- rtl/core/sparse_triplet_table.sv -----
// Sparse matrix kept as a sorted list of up to 64 (row, column, value)
// triplets in one memory with a single read port, stepped one entry a cycle.
// A request walks over the N stored triplets: lookup scans them in order,
// insert searches and then shifts up, clear resets the count without a walk,
// and transpose makes a full pass for every word it returns. A new request
// is taken once the previous one has handed its last word to the output
// register. Depends on sst_pkg, sst_if, sst_ctrl and sst_dp.
`timescale 1ns / 1ps

module sparse_triplet_table (
  input  logic                           clk,
  input  logic                           rst_n,
  sst_in_if.sink                         in_ch,
  sst_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sst_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sst_pkg::sst_cmd_t cmd;
  sst_pkg::sst_sts_t sts;

  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  sst_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- bench/tb_sparse_triplet_table.sv -----
// Testbench for the sparse triplet table: a predictor mirrors the sorted list and
// checks every result word in order. Depends on sst_pkg, sst_if and the block itself.
`timescale 1ns / 1ps

module tb_sparse_triplet_table;
  import sst_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   col;
    logic [VAL_W-1:0]   value;
    logic [ENTRY_W-1:0] total;
    logic               last;
  } triplet_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sst_in_if  in_ch ();
  sst_out_if out_ch ();

  sparse_triplet_table dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  logic [DIM_W-1:0] row_mirror [CAPACITY];
  logic [DIM_W-1:0] col_mirror [CAPACITY];
  logic [VAL_W-1:0] value_mirror [CAPACITY];
  int unsigned stored_count;
  logic [DIM_W-1:0] row_bound;
  logic [DIM_W-1:0] col_bound;
  triplet_result_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  bit hold_out = 1'b0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void push_result(logic [STAT_W-1:0] st, logic [DIM_W-1:0] r,
                                      logic [DIM_W-1:0] c, logic [VAL_W-1:0] v, logic lst);
    triplet_result_t res;
    res.status = st;
    res.row = r;
    res.col = c;
    res.value = v;
    res.total = stored_count[ENTRY_W-1:0];
    res.last = lst;
    pending_results.push_back(res);
  endfunction

  function automatic void apply_request(sst_req_t req, logic [DIM_W-1:0] r,
                                        logic [DIM_W-1:0] c, logic [VAL_W-1:0] v);
    int unsigned p;
    int unsigned k;
    sst_status_t st;
    p = 0;
    k = 0;
    st = ST_OK;
    case (req)
      REQ_INSERT: begin
        if (stored_count >= CAPACITY) begin
          st = ST_FULL;
        end else if (r == 0 || c == 0 || r > row_bound || c > col_bound) begin
          st = ST_RANGE;
        end else begin
          while (p < stored_count && {row_mirror[p], col_mirror[p]} < {r, c}) p++;
          if (p < stored_count && row_mirror[p] == r && col_mirror[p] == c) begin
            value_mirror[p] = v;
          end else begin
            for (int i = stored_count; i > p; i--) begin
              row_mirror[i] = row_mirror[i-1];
              col_mirror[i] = col_mirror[i-1];
              value_mirror[i] = value_mirror[i-1];
            end
            row_mirror[p] = r;
            col_mirror[p] = c;
            value_mirror[p] = v;
            stored_count++;
          end
        end
        push_result(st, '0, '0, '0, 1'b1);
      end
      REQ_LOOKUP: begin
        for (int i = 0; i < stored_count; i++) begin
          if (row_mirror[i] == r && col_mirror[i] == c) begin
            push_result(ST_OK, '0, '0, value_mirror[i], 1'b1);
            return;
          end
        end
        push_result(ST_NOTFOUND, '0, '0, '0, 1'b1);
      end
      REQ_TRANSPOSE: begin
        if (stored_count == 0) begin
          push_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (int cc = 0; cc < 256; cc++) begin
            for (int i = 0; i < stored_count; i++) begin
              if (col_mirror[i] == cc) begin
                k++;
                push_result(ST_OK, col_mirror[i], row_mirror[i], value_mirror[i],
                            k == stored_count);
              end
            end
          end
        end
      end
      default: begin
        stored_count = 0;
        push_result(ST_OK, '0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_request(sst_req_t req, logic [DIM_W-1:0] r, logic [DIM_W-1:0] c,
                              logic [VAL_W-1:0] v);
    int gap;
    in_ch.valid = 1'b1;
    in_ch.req_type = req;
    in_ch.row = r;
    in_ch.col = c;
    in_ch.value = v;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(req, r, c, v);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic finish_sending();
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    finish_sending();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_ROWS) row_bound = data;
    else if (idx == CFG_COLS) col_bound = data;
  endtask

  always @(negedge clk) begin
    if (hold_out) begin
      out_ch.ready = 1'b0;
    end else if ($urandom_range(99) < 15) begin
      out_ch.ready = 1'b0;
      repeat (pick_gap()) @(negedge clk);
      out_ch.ready = 1'b1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    triplet_result_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", out_ch.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) report_mismatch("status", out_ch.status, want.status);
        if (out_ch.out_row !== want.row) report_mismatch("out_row", out_ch.out_row, want.row);
        if (out_ch.out_col !== want.col) report_mismatch("out_col", out_ch.out_col, want.col);
        if (out_ch.out_value !== want.value)
          report_mismatch("out_value", out_ch.out_value, want.value);
        if (out_ch.entry_total !== want.total)
          report_mismatch("entry_total", out_ch.entry_total, want.total);
        if (out_ch.last !== want.last) report_mismatch("last", out_ch.last, want.last);
      end
    end
  end

  task automatic test_directed();
    send_request(REQ_TRANSPOSE, 8'd0, 8'd0, 32'h0);
    send_request(REQ_INSERT, 8'd1, 8'd1, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 8'd16, 8'd16, 32'h0000_0000);
    send_request(REQ_INSERT, 8'd3, 8'd2, 32'h3F80_0000);
    send_request(REQ_INSERT, 8'd2, 8'd3, 32'hBF80_0000);
    send_request(REQ_INSERT, 8'd3, 8'd2, 32'h4000_0000);
    send_request(REQ_INSERT, 8'd0, 8'd5, 32'h1);
    send_request(REQ_INSERT, 8'd5, 8'd0, 32'h2);
    send_request(REQ_INSERT, 8'd17, 8'd5, 32'h3);
    send_request(REQ_INSERT, 8'd5, 8'd17, 32'h4);
    send_request(REQ_INSERT, 8'd255, 8'd255, 32'h5);
    send_request(REQ_LOOKUP, 8'd3, 8'd2, 32'h0);
    send_request(REQ_LOOKUP, 8'd1, 8'd1, 32'h0);
    send_request(REQ_LOOKUP, 8'd4, 8'd4, 32'h0);
    send_request(REQ_LOOKUP, 8'd0, 8'd0, 32'h0);
    send_request(REQ_LOOKUP, 8'd255, 8'd255, 32'h0);
    send_request(REQ_TRANSPOSE, 8'd0, 8'd0, 32'h0);
    send_request(REQ_CLEAR, 8'd0, 8'd0, 32'h0);
    send_request(REQ_LOOKUP, 8'd1, 8'd1, 32'h0);
    send_request(REQ_TRANSPOSE, 8'd0, 8'd0, 32'h0);
    wait_drained();
  endtask

  task automatic test_bounds();
    write_reg(CFG_ROWS, 8'd255);
    write_reg(CFG_COLS, 8'd255);
    send_request(REQ_INSERT, 8'd255, 8'd255, 32'hA5A5_5A5A);
    send_request(REQ_INSERT, 8'd255, 8'd1, 32'h1234_5678);
    send_request(REQ_INSERT, 8'd128, 8'd127, 32'h8000_0000);
    send_request(REQ_TRANSPOSE, 8'd0, 8'd0, 32'h0);
    wait_drained();
    write_reg(CFG_ROWS, 8'd1);
    write_reg(CFG_COLS, 8'd1);
    send_request(REQ_INSERT, 8'd1, 8'd1, 32'h7);
    send_request(REQ_INSERT, 8'd2, 8'd1, 32'h8);
    send_request(REQ_INSERT, 8'd1, 8'd2, 32'h9);
    wait_drained();
    write_reg(CFG_ROWS, 8'd0);
    write_reg(CFG_COLS, 8'd0);
    send_request(REQ_INSERT, 8'd1, 8'd1, 32'hA);
    send_request(REQ_LOOKUP, 8'd255, 8'd1, 32'h0);
    wait_drained();
    write_reg(CFG_SPARE_LO, 8'd3);
    write_reg(CFG_SPARE_HI, 8'd200);
    write_reg(CFG_ROWS, 8'd16);
    write_reg(CFG_COLS, 8'd16);
    send_request(REQ_INSERT, 8'd16, 8'd16, 32'hB);
    send_request(REQ_CLEAR, 8'd0, 8'd0, 32'h0);
    wait_drained();
  endtask

  task automatic test_full_table();
    write_reg(CFG_ROWS, 8'd8);
    write_reg(CFG_COLS, 8'd8);
    for (int i = 0; i < CAPACITY; i++)
      send_request(REQ_INSERT, 8'(8 - i / 8), 8'(1 + (i * 3) % 8), $urandom());
    send_request(REQ_INSERT, 8'd1, 8'd1, 32'hDEAD_BEEF);
    send_request(REQ_INSERT, 8'd0, 8'd9, 32'h1);
    send_request(REQ_LOOKUP, 8'd8, 8'd8, 32'h0);
    send_request(REQ_TRANSPOSE, 8'd0, 8'd0, 32'h0);
    send_request(REQ_CLEAR, 8'd0, 8'd0, 32'h0);
    wait_drained();
  endtask

  task automatic test_output_stall();
    fork
      begin
        hold_out = 1'b1;
        repeat (300) @(negedge clk);
        hold_out = 1'b0;
      end
      begin
        for (int i = 0; i < 10; i++)
          send_request(i % 3 == 2 ? REQ_LOOKUP : REQ_INSERT, 8'($urandom_range(8, 1)),
                       8'($urandom_range(8, 1)), $urandom());
        send_request(REQ_TRANSPOSE, 8'd0, 8'd0, 32'h0);
        finish_sending();
      end
    join
    wait_drained();
  endtask

  task automatic test_random(int count);
    int roll;
    int pick;
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] c;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      r = 8'($urandom_range(row_bound, 1));
      c = 8'($urandom_range(col_bound, 1));
      if (roll < 55) begin
        if ($urandom_range(9) == 0) begin
          r = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 0));
          c = $urandom_range(1) ? 8'($urandom_range(255, 0)) : 8'd0;
        end
        send_request(REQ_INSERT, r, c, $urandom());
      end else if (roll < 88) begin
        if (stored_count != 0 && $urandom_range(2) != 0) begin
          pick = $urandom_range(stored_count - 1);
          r = row_mirror[pick];
          c = col_mirror[pick];
        end else if ($urandom_range(3) == 0) begin
          r = 8'($urandom());
          c = 8'($urandom());
        end
        send_request(REQ_LOOKUP, r, c, $urandom());
      end else if (roll < 96) begin
        send_request(REQ_TRANSPOSE, 8'($urandom()), 8'($urandom()), $urandom());
      end else begin
        send_request(REQ_CLEAR, 8'($urandom()), 8'($urandom()), $urandom());
      end
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_INSERT;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    stored_count = 0;
    row_bound = 8'd16;
    col_bound = 8'd16;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_bounds();
    test_full_table();
    test_output_stall();
    write_reg(CFG_ROWS, 8'd6);
    write_reg(CFG_COLS, 8'd5);
    test_random(27);
    write_reg(CFG_ROWS, 8'd255);
    write_reg(CFG_COLS, 8'd255);
    test_random(27);
    write_reg(CFG_ROWS, 8'($urandom_range(255, 1)));
    write_reg(CFG_COLS, 8'($urandom_range(12, 1)));
    test_random(27);
    write_reg(CFG_ROWS, 8'd3);
    write_reg(CFG_COLS, 8'd255);
    test_random(27);
    repeat (50) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sst_pkg.sv
rtl/core/sst_if.sv
rtl/core/sst_ram.sv
rtl/core/sst_ctrl.sv
rtl/core/sst_dp.sv
rtl/core/sparse_triplet_table.sv
bench/tb_sparse_triplet_table.sv
